FILE: rtl/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg: shared types and helpers for the JSON string unescaper
// Stage codes, error codes, result beat layout and the UTF-8 encode helpers.
// ----------------------------------------------------------------------------
package jsu_pkg;

  typedef enum logic [2:0] {
    ST_PLAIN   = 3'd0,
    ST_ESC     = 3'd1,
    ST_HEX1    = 3'd2,
    ST_NEED_BS = 3'd3,
    ST_NEED_U  = 3'd4,
    ST_HEX2    = 3'd5,
    ST_CLOSED  = 3'd6
  } stage_t;

  typedef enum logic [2:0] {
    ERR_NONE         = 3'd0,
    ERR_BAD_HEX      = 3'd1,
    ERR_BAD_SURR     = 3'd2,
    ERR_LINE_BREAK   = 3'd3,
    ERR_UNTERMINATED = 3'd4
  } err_t;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_U      = 8'h75;

  localparam logic [15:0] SURR_HI_FIRST = 16'hD800;
  localparam logic [15:0] SURR_HI_LAST  = 16'hDBFF;
  localparam logic [15:0] SURR_LO_FIRST = 16'hDC00;
  localparam logic [15:0] SURR_LO_LAST  = 16'hDFFF;
  localparam logic [20:0] SUPP_BASE     = 21'h10000;

  localparam int unsigned MAX_BEATS = 4;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       string_done;
    logic [2:0] error_code;
    logic       last_of_run;
  } result_t;

  typedef struct packed {
    result_t [MAX_BEATS-1:0] item;
    logic [2:0]              cnt;
  } burst_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] v;
  } hex_t;

  typedef struct packed {
    burst_t b;
    stage_t st;
    logic   clear;
  } plain_t;

  // Decode one ASCII hex digit
  function automatic hex_t hex_value(logic [7:0] c);
    hex_t h;
    h = '0;
    if (c inside {[8'h30:8'h39]}) begin
      h.ok = 1'b1;
      h.v  = 4'(c - 8'h30);
    end else if (c inside {[8'h61:8'h66]}) begin
      h.ok = 1'b1;
      h.v  = 4'(c - 8'h57);
    end else if (c inside {[8'h41:8'h46]}) begin
      h.ok = 1'b1;
      h.v  = 4'(c - 8'h37);
    end
    return h;
  endfunction

  // Append one result beat to a burst
  function automatic burst_t push(burst_t b, logic [7:0] by, logic bv, logic dn, err_t e);
    burst_t  r;
    result_t x;
    r             = b;
    x.out_byte    = by;
    x.byte_valid  = bv;
    x.string_done = dn;
    x.error_code  = e;
    x.last_of_run = 1'b0;
    if (b.cnt < 3'(MAX_BEATS)) begin
      r.item[b.cnt[1:0]] = x;
      r.cnt              = b.cnt + 3'd1;
    end
    return r;
  endfunction

  // Append the UTF-8 form of a code point
  function automatic burst_t encode(burst_t b, logic [20:0] cp);
    burst_t r;
    r = b;
    if (cp <= 21'h7F) begin
      r = push(r, cp[7:0], 1'b1, 1'b0, ERR_NONE);
    end else if (cp <= 21'h7FF) begin
      r = push(r, {3'b110, cp[10:6]}, 1'b1, 1'b0, ERR_NONE);
      r = push(r, {2'b10, cp[5:0]}, 1'b1, 1'b0, ERR_NONE);
    end else if (cp <= 21'hFFFF) begin
      r = push(r, {4'hE, cp[15:12]}, 1'b1, 1'b0, ERR_NONE);
      r = push(r, {2'b10, cp[11:6]}, 1'b1, 1'b0, ERR_NONE);
      r = push(r, {2'b10, cp[5:0]}, 1'b1, 1'b0, ERR_NONE);
    end else begin
      r = push(r, {5'b11110, cp[20:18]}, 1'b1, 1'b0, ERR_NONE);
      r = push(r, {2'b10, cp[17:12]}, 1'b1, 1'b0, ERR_NONE);
      r = push(r, {2'b10, cp[11:6]}, 1'b1, 1'b0, ERR_NONE);
      r = push(r, {2'b10, cp[5:0]}, 1'b1, 1'b0, ERR_NONE);
    end
    return r;
  endfunction

  // Handle a byte of ordinary string text
  function automatic plain_t plain_byte(burst_t b, logic [7:0] c);
    plain_t p;
    p.b     = b;
    p.st    = ST_PLAIN;
    p.clear = 1'b0;
    if (c == CH_QUOTE) begin
      p.b     = push(b, 8'h00, 1'b0, 1'b1, ERR_NONE);
      p.st    = ST_CLOSED;
      p.clear = 1'b1;
    end else if (c == CH_BSLASH) begin
      p.st = ST_ESC;
    end else if (c inside {CH_CR, CH_LF}) begin
      p.b     = push(b, 8'h00, 1'b0, 1'b0, ERR_LINE_BREAK);
      p.st    = ST_CLOSED;
      p.clear = 1'b1;
    end else begin
      p.b = push(b, c, 1'b1, 1'b0, ERR_NONE);
    end
    return p;
  endfunction

endpackage

FILE: rtl/jsu_in_if.sv
// ----------------------------------------------------------------------------
// jsu_in_if: raw byte channel into the unescaper
// Valid/ready channel carrying one string-body byte or an end marker per beat.
// ----------------------------------------------------------------------------
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       stream_end;

  modport source (output valid, output in_byte, output stream_end, input ready);
  modport sink   (input valid, input in_byte, input stream_end, output ready);
endinterface

FILE: rtl/jsu_out_if.sv
// ----------------------------------------------------------------------------
// jsu_out_if: decoded result channel out of the unescaper
// Valid/ready channel carrying one decoded byte or one status event per beat.
// ----------------------------------------------------------------------------
interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       string_done;
  logic [2:0] error_code;
  logic       last_of_run;

  modport source (output valid, output out_byte, output byte_valid, output string_done,
                  output error_code, output last_of_run, input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input string_done,
                  input error_code, input last_of_run, output ready);
endinterface

FILE: rtl/json_string_unescape_to_utf8_core.sv
// ----------------------------------------------------------------------------
// json_string_unescape_to_utf8_core: JSON string body to UTF-8 decoder
// Decodes escapes and \u surrogate pairs byte by byte, reports done/errors.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  takes one raw byte of the string body per beat, starting after the
//          opening quote; stream_end set marks the end of input.
//   out_ch gives one beat per decoded UTF-8 byte or status event (closing
//          quote or error); last_of_run marks the final beat of an input beat.
// Latency: the first result of an input beat is offered on the cycle after
//   it is taken. An input beat yields 0 to 4 result beats, which leave one
//   per cycle while out_ch.ready is high, from a four-entry burst register.
// Throughput: one input beat per cycle while each gives at most one result
//   and out_ch.ready is high; a beat giving more results holds the input
//   off until its last result beat leaves through the single result port
//   draining the burst register.
// Reset: the decoder returns to plain text and pending results are dropped.
// Stall: while out_ch.ready is low the burst holds; a new input beat is taken
//   only once the burst is empty or its last beat leaves in that cycle.
// ----------------------------------------------------------------------------
module json_string_unescape_to_utf8_core
  import jsu_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  jsu_in_if.sink    in_ch,
  jsu_out_if.source out_ch
);

  stage_t      stage_r, stage_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic [1:0]  dcnt_r, dcnt_nxt;
  logic [9:0]  saved_r, saved_nxt;

  result_t [MAX_BEATS-1:0] items_r;
  logic [2:0]              cnt_r;

  burst_t      bst;
  plain_t      pr;
  hex_t        hv;
  logic [15:0] acc_sh;
  logic [20:0] supp_cp;
  logic [1:0]  lidx;
  logic [7:0]  b;
  logic        take, pop;

  assign b    = in_ch.in_byte;
  assign take = in_ch.valid && in_ch.ready;
  assign pop  = out_ch.valid && out_ch.ready;

  // Accept while the burst is empty or draining its last beat
  assign in_ch.ready = (cnt_r == 3'd0) || (cnt_r == 3'd1 && out_ch.ready);

  // Present the head of the burst
  assign out_ch.valid       = (cnt_r != 3'd0);
  assign out_ch.out_byte    = items_r[0].out_byte;
  assign out_ch.byte_valid  = items_r[0].byte_valid;
  assign out_ch.string_done = items_r[0].string_done;
  assign out_ch.error_code  = items_r[0].error_code;
  assign out_ch.last_of_run = items_r[0].last_of_run;

  // Decode one input beat into a burst and the next decoder state
  always_comb begin
    bst       = '0;
    stage_nxt = stage_r;
    acc_nxt   = acc_r;
    dcnt_nxt  = dcnt_r;
    saved_nxt = saved_r;
    hv        = hex_value(b);
    acc_sh    = {acc_r[11:0], hv.v};
    supp_cp   = {1'b0, saved_r, acc_sh[9:0]} + SUPP_BASE;
    pr        = plain_byte('0, b);
    lidx      = '0;

    if (in_ch.stream_end) begin
      if (stage_r != ST_CLOSED) begin
        bst       = push(bst, 8'h00, 1'b0, 1'b0, ERR_UNTERMINATED);
        stage_nxt = ST_CLOSED;
        acc_nxt   = '0;
        dcnt_nxt  = '0;
        saved_nxt = '0;
      end
    end else begin
      case (stage_r)
        ST_ESC: begin
          stage_nxt = ST_PLAIN;
          case (b)
            CH_R:      bst = push(bst, CH_CR, 1'b1, 1'b0, ERR_NONE);
            CH_N:      bst = push(bst, CH_LF, 1'b1, 1'b0, ERR_NONE);
            CH_T:      bst = push(bst, CH_TAB, 1'b1, 1'b0, ERR_NONE);
            CH_F:      bst = push(bst, CH_FF, 1'b1, 1'b0, ERR_NONE);
            CH_QUOTE:  bst = push(bst, CH_QUOTE, 1'b1, 1'b0, ERR_NONE);
            CH_BSLASH: bst = push(bst, CH_BSLASH, 1'b1, 1'b0, ERR_NONE);
            CH_SLASH:  bst = push(bst, CH_SLASH, 1'b1, 1'b0, ERR_NONE);
            CH_B:      bst = push(bst, CH_BS, 1'b1, 1'b0, ERR_NONE);
            CH_U: begin
              stage_nxt = ST_HEX1;
              acc_nxt   = '0;
              dcnt_nxt  = '0;
              saved_nxt = '0;
            end
            default: begin
              // Unknown escape: emit the backslash, then treat the byte as text
              bst       = push(bst, CH_BSLASH, 1'b1, 1'b0, ERR_NONE);
              pr        = plain_byte(bst, b);
              bst       = pr.b;
              stage_nxt = pr.st;
              if (pr.clear) begin
                acc_nxt   = '0;
                dcnt_nxt  = '0;
                saved_nxt = '0;
              end
            end
          endcase
        end
        ST_HEX1, ST_HEX2: begin
          if (!hv.ok) begin
            bst       = push(bst, 8'h00, 1'b0, 1'b0, ERR_BAD_HEX);
            stage_nxt = ST_CLOSED;
            acc_nxt   = '0;
            dcnt_nxt  = '0;
            saved_nxt = '0;
          end else if (dcnt_r != 2'd3) begin
            acc_nxt  = acc_sh;
            dcnt_nxt = dcnt_r + 2'd1;
          end else if (stage_r == ST_HEX1) begin
            // First code unit complete
            acc_nxt  = '0;
            dcnt_nxt = '0;
            if (acc_sh inside {[SURR_HI_FIRST:SURR_HI_LAST]}) begin
              saved_nxt = acc_sh[9:0];
              stage_nxt = ST_NEED_BS;
            end else begin
              stage_nxt = ST_PLAIN;
              bst       = encode(bst, {5'b0, acc_sh});
            end
          end else begin
            // Low half of a surrogate pair complete
            acc_nxt   = '0;
            dcnt_nxt  = '0;
            saved_nxt = '0;
            if (acc_sh inside {[SURR_LO_FIRST:SURR_LO_LAST]}) begin
              stage_nxt = ST_PLAIN;
              bst       = encode(bst, supp_cp);
            end else begin
              stage_nxt = ST_CLOSED;
              bst       = push(bst, 8'h00, 1'b0, 1'b0, ERR_BAD_SURR);
            end
          end
        end
        ST_NEED_BS: begin
          if (b == CH_BSLASH) begin
            stage_nxt = ST_NEED_U;
          end else begin
            bst       = push(bst, 8'h00, 1'b0, 1'b0, ERR_BAD_SURR);
            stage_nxt = ST_CLOSED;
            acc_nxt   = '0;
            dcnt_nxt  = '0;
            saved_nxt = '0;
          end
        end
        ST_NEED_U: begin
          if (b == CH_U) begin
            stage_nxt = ST_HEX2;
            acc_nxt   = '0;
            dcnt_nxt  = '0;
          end else begin
            bst       = push(bst, 8'h00, 1'b0, 1'b0, ERR_BAD_SURR);
            stage_nxt = ST_CLOSED;
            acc_nxt   = '0;
            dcnt_nxt  = '0;
            saved_nxt = '0;
          end
        end
        default: begin
          bst       = pr.b;
          stage_nxt = pr.st;
          if (pr.clear) begin
            acc_nxt   = '0;
            dcnt_nxt  = '0;
            saved_nxt = '0;
          end
        end
      endcase
    end

    // Mark the final beat of the burst
    if (bst.cnt != 3'd0) begin
      lidx = 2'(bst.cnt - 3'd1);
      bst.item[lidx].last_of_run = 1'b1;
    end
  end

  // Advance decoder state on each accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r <= ST_PLAIN;
      acc_r   <= '0;
      dcnt_r  <= '0;
      saved_r <= '0;
    end else if (take) begin
      stage_r <= stage_nxt;
      acc_r   <= acc_nxt;
      dcnt_r  <= dcnt_nxt;
      saved_r <= saved_nxt;
    end
  end

  // Load a fresh burst or shift out the head beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (take) begin
      cnt_r <= bst.cnt;
    end else if (pop) begin
      cnt_r <= cnt_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      items_r <= bst.item;
    end else if (pop) begin
      items_r <= {items_r[MAX_BEATS-1], items_r[MAX_BEATS-1:1]};
    end
  end

`ifndef NO_ASSERTIONS
  logic [1:0] tail_idx;
  assign tail_idx = 2'(cnt_r - 3'd1);

  a_take_only_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    take |-> (cnt_r == 3'd0 || (cnt_r == 3'd1 && pop)))
    else $error("input beat taken over a pending burst");

  a_burst_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'(MAX_BEATS))
    else $error("burst count beyond capacity");

  a_tail_marked: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != 3'd0) |-> items_r[tail_idx].last_of_run)
    else $error("burst tail lacks last_of_run");

  a_event_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.error_code != ERR_NONE || out_ch.string_done))
      |-> (!out_ch.byte_valid && out_ch.last_of_run))
    else $error("status beat carries a byte or is not last");

  a_closed_end_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (take && in_ch.stream_end && stage_r == ST_CLOSED) |=> (cnt_r == 3'd0))
    else $error("end marker after close produced a result");
`endif

endmodule

FILE: tb/tb_json_string_unescape_to_utf8_core.sv
// ----------------------------------------------------------------------------
// tb_json_string_unescape_to_utf8_core: self-checking bench for the unescaper
// Feeds string-body bytes and end markers through the input channel. A local
// decoder model predicts the result beats of every accepted input beat, and
// each result beat is checked against the oldest prediction, field by field.
// Both channels stall at random until the tail of the run.
// ----------------------------------------------------------------------------
module tb_json_string_unescape_to_utf8_core;
  import jsu_pkg::*;

  localparam int TAIL_ITEMS   = 30;
  localparam int RANDOM_ITEMS = 250;

  typedef struct packed {
    logic [7:0] b;
    logic       fin;
  } body_item_t;

  logic clk;
  logic rst_n;

  jsu_in_if  in_ch();
  jsu_out_if out_ch();

  json_string_unescape_to_utf8_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  body_item_t pending_items[$];
  result_t    expected_beats[$];
  body_item_t next_item;
  int         accepted_cnt  = 0;
  int         total_items   = 0;
  int         mismatch_cnt  = 0;
  int         send_gap      = 0;
  int         hold_cnt      = 0;

  // Decoder model state, at its reset values
  stage_t      text_stage = ST_PLAIN;
  logic [15:0] unit_acc   = '0;
  logic [1:0]  digit_cnt  = '0;
  logic [9:0]  high_ten   = '0;

  // Clock, and known levels on every input from time zero
  initial begin
    clk              = 1'b0;
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.in_byte    = '0;
    in_ch.stream_end = 1'b0;
    out_ch.ready     = 1'b0;
    forever #6 clk = ~clk;
  end

  // Print one line per mismatch and count it
  task automatic flag(input string what);
    mismatch_cnt++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) flag($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
  endtask

  // ---------------------------------------------------------------- model --

  task automatic emit(input logic [7:0] by, input logic bv, input logic dn, input err_t e);
    result_t r;
    r.out_byte    = by;
    r.byte_valid  = bv;
    r.string_done = dn;
    r.error_code  = e;
    r.last_of_run = 1'b0;
    expected_beats.push_back(r);
  endtask

  task automatic restart(input stage_t s);
    text_stage = s;
    unit_acc   = '0;
    digit_cnt  = '0;
    high_ten   = '0;
  endtask

  task automatic abort_string(input err_t e);
    restart(ST_CLOSED);
    emit(8'h00, 1'b0, 1'b0, e);
  endtask

  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return {1'b1, 4'(c - 8'h30)};
    if (c >= 8'h61 && c <= 8'h66) return {1'b1, 4'(c - 8'h61 + 8'd10)};
    if (c >= 8'h41 && c <= 8'h46) return {1'b1, 4'(c - 8'h41 + 8'd10)};
    return 5'b0;
  endfunction

  // UTF-8 form of one code point
  task automatic put_code_point(input logic [20:0] cp);
    if (cp <= 21'h7F) begin
      emit(cp[7:0], 1'b1, 1'b0, ERR_NONE);
    end else if (cp <= 21'h7FF) begin
      emit(8'(cp >> 6) | 8'hC0, 1'b1, 1'b0, ERR_NONE);
      emit(8'(cp & 21'h3F) | 8'h80, 1'b1, 1'b0, ERR_NONE);
    end else if (cp <= 21'hFFFF) begin
      emit(8'(cp >> 12) | 8'hE0, 1'b1, 1'b0, ERR_NONE);
      emit(8'((cp >> 6) & 21'h3F) | 8'h80, 1'b1, 1'b0, ERR_NONE);
      emit(8'(cp & 21'h3F) | 8'h80, 1'b1, 1'b0, ERR_NONE);
    end else begin
      emit(8'((cp >> 18) & 21'h07) | 8'hF0, 1'b1, 1'b0, ERR_NONE);
      emit(8'((cp >> 12) & 21'h3F) | 8'h80, 1'b1, 1'b0, ERR_NONE);
      emit(8'((cp >> 6) & 21'h3F) | 8'h80, 1'b1, 1'b0, ERR_NONE);
      emit(8'(cp & 21'h3F) | 8'h80, 1'b1, 1'b0, ERR_NONE);
    end
  endtask

  // Ordinary text byte: quote closes, backslash opens an escape, CR/LF fail
  task automatic text_byte(input logic [7:0] b);
    if (b == CH_QUOTE) begin
      restart(ST_CLOSED);
      emit(8'h00, 1'b0, 1'b1, ERR_NONE);
    end else if (b == CH_BSLASH) begin
      text_stage = ST_ESC;
    end else if (b == CH_CR || b == CH_LF) begin
      abort_string(ERR_LINE_BREAK);
    end else begin
      text_stage = ST_PLAIN;
      emit(b, 1'b1, 1'b0, ERR_NONE);
    end
  endtask

  // Predict the result beats of one accepted input beat
  task automatic unescape_byte(input logic [7:0] b, input logic fin);
    int          base;
    logic [4:0]  nib;
    logic [15:0] unit;
    base = expected_beats.size();
    if (fin) begin
      if (text_stage != ST_CLOSED) abort_string(ERR_UNTERMINATED);
    end else begin
      case (text_stage)
        ST_ESC: begin
          text_stage = ST_PLAIN;
          case (b)
            CH_R:      emit(CH_CR, 1'b1, 1'b0, ERR_NONE);
            CH_N:      emit(CH_LF, 1'b1, 1'b0, ERR_NONE);
            CH_T:      emit(CH_TAB, 1'b1, 1'b0, ERR_NONE);
            CH_F:      emit(CH_FF, 1'b1, 1'b0, ERR_NONE);
            CH_QUOTE:  emit(CH_QUOTE, 1'b1, 1'b0, ERR_NONE);
            CH_BSLASH: emit(CH_BSLASH, 1'b1, 1'b0, ERR_NONE);
            CH_SLASH:  emit(CH_SLASH, 1'b1, 1'b0, ERR_NONE);
            CH_B:      emit(CH_BS, 1'b1, 1'b0, ERR_NONE);
            CH_U:      restart(ST_HEX1);
            default: begin
              emit(CH_BSLASH, 1'b1, 1'b0, ERR_NONE);
              text_byte(b);
            end
          endcase
        end
        ST_HEX1, ST_HEX2: begin
          nib = hex_nibble(b);
          if (!nib[4]) begin
            abort_string(ERR_BAD_HEX);
          end else if (digit_cnt != 2'd3) begin
            unit_acc  = {unit_acc[11:0], nib[3:0]};
            digit_cnt = digit_cnt + 2'd1;
          end else begin
            unit      = {unit_acc[11:0], nib[3:0]};
            unit_acc  = '0;
            digit_cnt = '0;
            if (text_stage == ST_HEX1) begin
              if (unit >= SURR_HI_FIRST && unit <= SURR_HI_LAST) begin
                high_ten   = unit[9:0];
                text_stage = ST_NEED_BS;
              end else begin
                text_stage = ST_PLAIN;
                put_code_point(21'(unit));
              end
            end else if (unit >= SURR_LO_FIRST && unit <= SURR_LO_LAST) begin
              nib = '0;
              put_code_point(21'({high_ten, unit[9:0]}) + SUPP_BASE);
              restart(ST_PLAIN);
            end else begin
              abort_string(ERR_BAD_SURR);
            end
          end
        end
        ST_NEED_BS: begin
          if (b == CH_BSLASH) text_stage = ST_NEED_U;
          else abort_string(ERR_BAD_SURR);
        end
        ST_NEED_U: begin
          if (b == CH_U) begin
            text_stage = ST_HEX2;
            unit_acc   = '0;
            digit_cnt  = '0;
          end else begin
            abort_string(ERR_BAD_SURR);
          end
        end
        default: text_byte(b);
      endcase
    end
    if (expected_beats.size() > base) expected_beats[$].last_of_run = 1'b1;
  endtask

  // ------------------------------------------------------------- stimulus --

  task automatic add_byte(input logic [7:0] b);
    body_item_t it;
    it.b   = b;
    it.fin = 1'b0;
    pending_items.push_back(it);
  endtask

  // End marker; the byte lane carries junk that must be ignored
  task automatic add_end();
    body_item_t it;
    it.b   = 8'($urandom_range(0, 255));
    it.fin = 1'b1;
    pending_items.push_back(it);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
  endfunction

  task automatic add_digits(input logic [15:0] u, input int n);
    for (int i = 3; i > 3 - n; i--) add_byte(hex_char(u[i*4 +: 4]));
  endtask

  task automatic add_unit(input logic [15:0] u);
    add_byte(CH_BSLASH);
    add_byte(CH_U);
    add_digits(u, 4);
  endtask

  function automatic logic [15:0] high_unit();
    return SURR_HI_FIRST + 16'($urandom_range(0, 16'h3FF));
  endfunction

  function automatic logic [7:0] text_char();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    while (c == CH_QUOTE || c == CH_BSLASH || c == CH_CR || c == CH_LF)
      c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  function automatic logic [7:0] escape_letter();
    logic [7:0] letters [8];
    letters = '{CH_R, CH_N, CH_T, CH_F, CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B};
    return letters[$urandom_range(0, 7)];
  endfunction

  // A byte after a backslash that names no escape (may still be a CR or LF)
  function automatic logic [7:0] odd_letter();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    while (c == CH_R || c == CH_N || c == CH_T || c == CH_F || c == CH_QUOTE ||
           c == CH_BSLASH || c == CH_SLASH || c == CH_B || c == CH_U)
      c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  // Non-hex byte, often one just outside a digit range
  function automatic logic [7:0] non_hex_char();
    logic [7:0] edges [6];
    logic [7:0] c;
    logic [4:0] h;
    edges = '{8'h2F, 8'h3A, 8'h40, 8'h47, 8'h60, 8'h67};
    if ($urandom_range(0, 1)) return edges[$urandom_range(0, 5)];
    c = 8'($urandom_range(0, 255));
    h = hex_nibble(c);
    while (h[4]) begin
      c = 8'($urandom_range(0, 255));
      h = hex_nibble(c);
    end
    return c;
  endfunction

  // Single \u unit outside the high-surrogate range, across the one-, two- and three-byte UTF-8 lengths
  function automatic logic [15:0] bmp_unit();
    case ($urandom_range(0, 4))
      0:       return 16'($urandom_range(0, 16'h7F));
      1:       return 16'($urandom_range(16'h80, 16'h7FF));
      2:       return 16'($urandom_range(16'h800, 16'hD7FF));
      3:       return 16'($urandom_range(16'hE000, 16'hFFFF));
      default: return 16'($urandom_range(SURR_LO_FIRST, SURR_LO_LAST));
    endcase
  endfunction

  // String body with random content, closed by a quote or cut short; an odd escape byte may be a CR or LF
  task automatic add_body();
    int pieces;
    pieces = $urandom_range(1, 6);
    for (int p = 0; p < pieces; p++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: add_byte(text_char());
        3: begin
          add_byte(CH_BSLASH);
          add_byte(escape_letter());
        end
        4, 5: add_unit(bmp_unit());
        6, 7: begin
          add_unit(high_unit());
          add_unit(SURR_LO_FIRST + 16'($urandom_range(0, 16'h3FF)));
        end
        8: begin
          add_byte(CH_BSLASH);
          add_byte(odd_letter());
        end
        default: repeat ($urandom_range(2, 4)) add_byte(text_char());
      endcase
    end
    if ($urandom_range(0, 9) == 0) add_end();
    else add_byte(CH_QUOTE);
  endtask

  // Broken sequences and noise
  task automatic add_broken();
    logic [15:0] u;
    case ($urandom_range(0, 6))
      0: begin
        add_byte(CH_BSLASH);
        add_byte(CH_U);
        add_digits(16'($urandom_range(0, 16'hFFFF)), $urandom_range(0, 3));
        add_byte(non_hex_char());
      end
      1: begin
        add_unit(high_unit());
        u = {8'h00, text_char()};
        if ($urandom_range(0, 3) == 0) u = {8'h00, CH_QUOTE};
        add_byte(u[7:0]);
      end
      2: begin
        add_unit(high_unit());
        add_byte(CH_BSLASH);
        add_byte($urandom_range(0, 1) ? odd_letter() : CH_QUOTE);
      end
      3: begin
        add_unit(high_unit());
        add_byte(CH_BSLASH);
        add_byte(CH_U);
        if ($urandom_range(0, 2) == 0) begin
          add_digits(16'($urandom_range(0, 16'hFFFF)), $urandom_range(0, 3));
          add_byte(non_hex_char());
        end else begin
          u = 16'($urandom_range(0, 16'hFFFF));
          while (u >= SURR_LO_FIRST && u <= SURR_LO_LAST) u = 16'($urandom_range(0, 16'hFFFF));
          add_digits(u, 4);
        end
      end
      4: begin
        if ($urandom_range(0, 1)) add_byte(text_char());
        add_byte($urandom_range(0, 1) ? CH_CR : CH_LF);
      end
      5: begin
        // cut the input inside an escape
        case ($urandom_range(0, 3))
          0: add_byte(CH_BSLASH);
          1: begin
            add_byte(CH_BSLASH);
            add_byte(CH_U);
            add_digits(16'($urandom_range(0, 16'hFFFF)), $urandom_range(0, 3));
          end
          2: begin
            add_unit(high_unit());
            if ($urandom_range(0, 1)) add_byte(CH_BSLASH);
          end
          default: begin
            add_unit(high_unit());
            add_byte(CH_BSLASH);
            add_byte(CH_U);
            add_digits(16'($urandom_range(0, 16'hFFFF)), $urandom_range(0, 3));
          end
        endcase
        add_end();
      end
      default: begin
        repeat ($urandom_range(1, 4)) add_byte(8'($urandom_range(0, 255)));
        add_byte(CH_QUOTE);
        add_end();
      end
    endcase
  endtask

  // --------------------------------------------------------------- driver --

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      // Predict from the beat taken at this edge
      if (in_ch.valid && in_ch.ready) begin
        unescape_byte(in_ch.in_byte, in_ch.stream_end);
        accepted_cnt++;
      end
      // Load the next beat, or idle for a short burst
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_ch.valid <= 1'b0;
        end else if (pending_items.size() > TAIL_ITEMS && $urandom_range(0, 5) == 0) begin
          send_gap = $urandom_range(0, 2);
          in_ch.valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          next_item = pending_items.pop_front();
          in_ch.valid      <= 1'b1;
          in_ch.in_byte    <= next_item.b;
          in_ch.stream_end <= next_item.fin;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // -------------------------------------------------------------- monitor --

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      // Check the result beat taken at this edge
      if (out_ch.valid && out_ch.ready) begin
        if (expected_beats.size() == 0) begin
          flag($sformatf("unexpected beat, byte 0x%0h", out_ch.out_byte));
        end else begin
          want = expected_beats.pop_front();
          check_field("out_byte", out_ch.out_byte, want.out_byte);
          check_field("byte_valid", out_ch.byte_valid, want.byte_valid);
          check_field("string_done", out_ch.string_done, want.string_done);
          check_field("error_code", out_ch.error_code, want.error_code);
          check_field("last_of_run", out_ch.last_of_run, want.last_of_run);
        end
      end
      // Stall in short bursts until the tail of the run
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ch.ready <= 1'b0;
      end else if (pending_items.size() > TAIL_ITEMS && $urandom_range(0, 4) == 0) begin
        hold_cnt = $urandom_range(0, 2);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // ------------------------------------------------------------- sequence --

  initial begin
    // Extremes, unknown escape, a known escape, the top supplementary code
    // point, a close, a line break, an end marker while closed, a cut string
    logic [7:0] opening [20];
    opening = '{8'h00, 8'hFF, CH_BSLASH, 8'h71, CH_BSLASH, CH_N,
                CH_BSLASH, CH_U, 8'h44, 8'h62, 8'h46, 8'h66,
                CH_BSLASH, CH_U, 8'h44, 8'h46, 8'h46, 8'h46,
                CH_QUOTE, CH_LF};
    foreach (opening[i]) add_byte(opening[i]);
    add_end();
    add_byte(8'h78);
    add_end();

    total_items = pending_items.size() + RANDOM_ITEMS;
    while (pending_items.size() < total_items) begin
      if ($urandom_range(0, 3) == 0) add_broken();
      else add_body();
    end
    total_items = pending_items.size();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted_cnt < total_items || expected_beats.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (mismatch_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

FILE: json_string_unescape_to_utf8_core.f
rtl/jsu_pkg.sv
rtl/jsu_in_if.sv
rtl/jsu_out_if.sv
rtl/json_string_unescape_to_utf8_core.sv
tb/tb_json_string_unescape_to_utf8_core.sv
